FILE: design/eds_pkg.sv
// eds_pkg: constants, types and codes for the edit distance similarity block
// no dependencies; used by edit_distance_similarity
`default_nettype none

package eds_pkg;

   localparam int MAX_LEN  = 64;
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CHAR_W   = 8;
   localparam int ACTION_W = 2;
   localparam int SIM_W    = 17;
   localparam int DIST_W   = 7;
   localparam int FRAC_W   = 16;
   localparam int NUM_W    = LEN_W + FRAC_W;
   localparam int CNT_W    = $clog2(NUM_W + 1);

   localparam logic [CHAR_W-1:0] DASH_CHAR = 8'h2D;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [NUM_W-1:0]  num_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SIM_W-1:0]  sim_type;
   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [LEN_W:0]    rem_ext_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FIRST   = 2'd0,
      ACT_SECOND  = 2'd1,
      ACT_COMPARE = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CELL_READ,
      ST_CELL_CALC,
      ST_SETUP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: design/edit_distance_similarity.sv
// edit_distance_similarity: levenshtein distance and similarity of two loaded strings
// depends on eds_pkg; holds both strings and one dp row in local memories
//
// input words (req_) carry an action and a character: append to the first
// string, append to the second, or compare. appends are taken in the idle
// state; a character beyond MAX_LEN is dropped and flagged as overflow. a
// compare runs the dp cell by cell on one shared min/add unit and then a
// restoring divider for the Q1.16 similarity (empty strings skip the dp,
// forced zero similarity skips the divider). req_ready is low throughout.
// one result word (rsp_) per compare, held in an output register; appends are
// taken while it waits. if the receiver stalls, a finished compare waits in
// the done state until the output register frees. both strings and the
// overflow flag clear when the result is loaded. reset empties both strings,
// clears the flag and drops any pending result.
`default_nettype none

module edit_distance_similarity (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [eds_pkg::ACTION_W-1:0] req_action,
   input  wire logic [eds_pkg::CHAR_W-1:0]   req_char_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [eds_pkg::SIM_W-1:0]    rsp_similarity,
   output      logic [eds_pkg::DIST_W-1:0]   rsp_distance,
   output      logic                         rsp_overflow
);

   eds_pkg::char_type first_mem  [eds_pkg::MAX_LEN];
   eds_pkg::char_type second_mem [eds_pkg::MAX_LEN];
   eds_pkg::len_type  dp_mem     [eds_pkg::MAX_LEN];

   eds_pkg::state_type state_ff, state_in;

   eds_pkg::len_type  first_len_ff, first_len_in;
   eds_pkg::len_type  second_len_ff, second_len_in;
   logic              overflow_ff, overflow_in;
   logic              first_dash_ff, first_dash_in;
   logic              second_dash_ff, second_dash_in;
   eds_pkg::idx_type  row_ff, row_in;
   eds_pkg::idx_type  col_ff, col_in;
   eds_pkg::len_type  left_ff, left_in;
   eds_pkg::len_type  diag_ff, diag_in;
   eds_pkg::len_type  dist_ff, dist_in;
   eds_pkg::num_type  num_ff, num_in;
   eds_pkg::len_type  rem_ff, rem_in;
   eds_pkg::sim_type  quo_ff, quo_in;
   eds_pkg::cnt_type  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   eds_pkg::sim_type  rsp_sim_ff, rsp_sim_in;
   eds_pkg::dist_type rsp_dist_ff, rsp_dist_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   eds_pkg::char_type first_rd_ff;
   eds_pkg::char_type second_rd_ff;
   eds_pkg::len_type  dp_rd_ff;

   logic              first_we, second_we, dp_we;
   eds_pkg::len_type  dp_wdata;

   logic              req_fire;
   logic              is_compare;
   logic              col_last, row_last;
   logic              any_empty, zero_sim, out_free;
   eds_pkg::len_type  max_len;
   eds_pkg::len_type  col_ext, row_ext;
   eds_pkg::len_type  min_ld, min_all, cell_value;
   eds_pkg::rem_ext_type rem_shift;
   logic              rem_ge;

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem[first_len_ff[eds_pkg::IDX_W-1:0]] <= req_char_value;
      end
      first_rd_ff <= first_mem[row_ff];
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_mem[second_len_ff[eds_pkg::IDX_W-1:0]] <= req_char_value;
      end
      second_rd_ff <= second_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (dp_we) begin
         dp_mem[col_ff] <= dp_wdata;
      end
      dp_rd_ff <= dp_mem[col_ff];
   end

   assign req_ready  = (state_ff == eds_pkg::ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign is_compare = (req_action == eds_pkg::ACT_COMPARE);

   assign col_ext  = eds_pkg::len_type'(col_ff);
   assign row_ext  = eds_pkg::len_type'(row_ff);
   assign col_last = ((col_ext + eds_pkg::len_type'(1)) == second_len_ff);
   assign row_last = ((row_ext + eds_pkg::len_type'(1)) == first_len_ff);
   assign max_len  = (first_len_ff > second_len_ff) ? first_len_ff : second_len_ff;
   assign any_empty = (first_len_ff == '0) || (second_len_ff == '0);
   assign zero_sim = any_empty
                  || ((first_len_ff == eds_pkg::len_type'(1)) && first_dash_ff
                      && !((second_len_ff == eds_pkg::len_type'(1)) && second_dash_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // shared cell unit: min of left, above, diagonal plus one, or diagonal on match
   assign min_ld     = (left_ff < diag_ff) ? left_ff : diag_ff;
   assign min_all    = (dp_rd_ff < min_ld) ? dp_rd_ff : min_ld;
   assign cell_value = (first_rd_ff == second_rd_ff) ? diag_ff
                                                     : min_all + eds_pkg::len_type'(1);

   // restoring divider step
   assign rem_shift = {rem_ff, num_ff[eds_pkg::NUM_W-1]};
   assign rem_ge    = (rem_shift >= eds_pkg::rem_ext_type'(max_len));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eds_pkg::ST_IDLE: begin
            if (req_fire && is_compare) begin
               state_in = any_empty ? eds_pkg::ST_SETUP : eds_pkg::ST_INIT;
            end
         end
         eds_pkg::ST_INIT: begin
            if (col_last) begin
               state_in = eds_pkg::ST_CELL_READ;
            end
         end
         eds_pkg::ST_CELL_READ: begin
            state_in = eds_pkg::ST_CELL_CALC;
         end
         eds_pkg::ST_CELL_CALC: begin
            if (col_last && row_last) begin
               state_in = eds_pkg::ST_SETUP;
            end else begin
               state_in = eds_pkg::ST_CELL_READ;
            end
         end
         eds_pkg::ST_SETUP: begin
            state_in = zero_sim ? eds_pkg::ST_DONE : eds_pkg::ST_DIVIDE;
         end
         eds_pkg::ST_DIVIDE: begin
            if (cnt_ff == eds_pkg::cnt_type'(1)) begin
               state_in = eds_pkg::ST_DONE;
            end
         end
         eds_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = eds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eds_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      first_len_in   = first_len_ff;
      second_len_in  = second_len_ff;
      overflow_in    = overflow_ff;
      first_dash_in  = first_dash_ff;
      second_dash_in = second_dash_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      left_in        = left_ff;
      diag_in        = diag_ff;
      dist_in        = dist_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_sim_in     = rsp_sim_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      first_we       = 1'b0;
      second_we      = 1'b0;
      dp_we          = 1'b0;
      dp_wdata       = col_ext + eds_pkg::len_type'(1);
      case (state_ff)
         eds_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  eds_pkg::ACT_FIRST: begin
                     if (first_len_ff < eds_pkg::len_type'(eds_pkg::MAX_LEN)) begin
                        first_we     = 1'b1;
                        first_len_in = first_len_ff + eds_pkg::len_type'(1);
                        if (first_len_ff == '0) begin
                           first_dash_in = (req_char_value == eds_pkg::DASH_CHAR);
                        end
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  eds_pkg::ACT_SECOND: begin
                     if (second_len_ff < eds_pkg::len_type'(eds_pkg::MAX_LEN)) begin
                        second_we     = 1'b1;
                        second_len_in = second_len_ff + eds_pkg::len_type'(1);
                        if (second_len_ff == '0) begin
                           second_dash_in = (req_char_value == eds_pkg::DASH_CHAR);
                        end
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  eds_pkg::ACT_COMPARE: begin
                     col_in  = '0;
                     row_in  = '0;
                     dist_in = max_len;
                  end
                  default: begin
                  end
               endcase
            end
         end
         eds_pkg::ST_INIT: begin
            // first dp row holds its column number
            dp_we = 1'b1;
            if (col_last) begin
               col_in  = '0;
               row_in  = '0;
               left_in = eds_pkg::len_type'(1);
               diag_in = '0;
            end else begin
               col_in = col_ff + eds_pkg::idx_type'(1);
            end
         end
         eds_pkg::ST_CELL_CALC: begin
            dp_we    = 1'b1;
            dp_wdata = cell_value;
            if (col_last) begin
               dist_in = cell_value;
               col_in  = '0;
               if (!row_last) begin
                  row_in  = row_ff + eds_pkg::idx_type'(1);
                  left_in = row_ext + eds_pkg::len_type'(2);
                  diag_in = row_ext + eds_pkg::len_type'(1);
               end
            end else begin
               col_in  = col_ff + eds_pkg::idx_type'(1);
               left_in = cell_value;
               diag_in = dp_rd_ff;
            end
         end
         eds_pkg::ST_SETUP: begin
            num_in = eds_pkg::num_type'(max_len - dist_ff) << eds_pkg::FRAC_W;
            rem_in = '0;
            quo_in = '0;
            cnt_in = eds_pkg::cnt_type'(eds_pkg::NUM_W);
         end
         eds_pkg::ST_DIVIDE: begin
            num_in = num_ff << 1;
            rem_in = rem_ge ? eds_pkg::len_type'(rem_shift - eds_pkg::rem_ext_type'(max_len))
                            : eds_pkg::len_type'(rem_shift);
            quo_in = {quo_ff[eds_pkg::SIM_W-2:0], rem_ge};
            cnt_in = cnt_ff - eds_pkg::cnt_type'(1);
         end
         eds_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sim_in     = quo_ff;
               rsp_dist_in    = eds_pkg::dist_type'(dist_ff);
               rsp_ovf_in     = overflow_ff;
               first_len_in   = '0;
               second_len_in  = '0;
               overflow_in    = 1'b0;
               first_dash_in  = 1'b0;
               second_dash_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= eds_pkg::ST_IDLE;
         first_len_ff   <= '0;
         second_len_ff  <= '0;
         overflow_ff    <= 1'b0;
         first_dash_ff  <= 1'b0;
         second_dash_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         first_len_ff   <= first_len_in;
         second_len_ff  <= second_len_in;
         overflow_ff    <= overflow_in;
         first_dash_ff  <= first_dash_in;
         second_dash_ff <= second_dash_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      left_ff     <= left_in;
      diag_ff     <= diag_in;
      dist_ff     <= dist_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      rsp_sim_ff  <= rsp_sim_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = rsp_sim_ff;
   assign rsp_distance   = rsp_dist_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

`default_nettype wire
